// ===== sv/rpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_pkg
// Shared types, character codes and helpers of the packet deframer.
// ----------------------------------------------------------------------------
package rpd_pkg;

  typedef enum logic [3:0] {
    KIND_PAYLOAD   = 4'd0,
    KIND_ACK       = 4'd1,
    KIND_RETX      = 4'd2,
    KIND_INTR      = 4'd3,
    KIND_PKT_OK    = 4'd4,
    KIND_EMPTY_OK  = 4'd5,
    KIND_BAD_CSUM  = 4'd6,
    KIND_INVALID   = 4'd7,
    KIND_TRUNCATED = 4'd8,
    KIND_EOF_IDLE  = 4'd9
  } kind_e;

  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_INTR   = 8'h63;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_ESC    = 8'h7d;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] ESC_XOR   = 8'h20;
  localparam logic [7:0] REP_BIAS  = 8'd29;
  localparam logic [7:0] REP_TOP   = 8'd155;

  localparam int unsigned MaxRes = 3;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [6:0]  repeat_res;
    logic [6:0]  seq_id;
    logic        seq_valid;
    logic [7:0]  checksum;
  } res_t;

  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MaxRes-1:0]      res;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, b[3:0]};
    end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, 4'(b[3:0] + 4'd9)};
    end
    return r;
  endfunction

endpackage

// ===== sv/rpd_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_in_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface rpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_stream;

  modport source (output valid, output rx_byte, output end_of_stream, input ready);
  modport sink (input valid, input rx_byte, input end_of_stream, output ready);
endinterface

// ===== sv/rpd_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_out_if
// Decoded result channel.
// ----------------------------------------------------------------------------
interface rpd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] kind;
  logic [7:0] data;
  logic [6:0] repeat_res;
  logic [6:0] seq_id;
  logic       seq_valid;
  logic [7:0] checksum;
  logic       last;

  modport source (output valid, output kind, output data, output repeat_res,
                  output seq_id, output seq_valid, output checksum, output last,
                  input ready);
  modport sink (input valid, input kind, input data, input repeat_res,
                input seq_id, input seq_valid, input checksum, input last,
                output ready);
endinterface

// ===== sv/rpd_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_cfg_if
// Configuration write channel for the rle enable register.
// ----------------------------------------------------------------------------
interface rpd_cfg_if;
  logic valid;
  logic ready;
  logic rle_enable;

  modport source (output valid, output rle_enable, input ready);
  modport sink (input valid, input rle_enable, output ready);
endinterface

// ===== sv/rpd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_front
// Per-byte framing state machine; turns each byte into a bundle of results.
// ----------------------------------------------------------------------------
module rpd_front import rpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rle_enable_i,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  input  logic       eos_i,
  output logic       push_o,
  output bundle_t    bundle_o
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_CK1  = 2'd2,
    PH_CK2  = 2'd3
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] sum_q, sum_d;
  logic       esc_q, esc_d;
  logic       rep_q, rep_d;
  logic [7:0] last_data_q, last_data_d;
  logic [7:0] held0_q, held0_d;
  logic [7:0] held1_q, held1_d;
  logic [1:0] held_cnt_q, held_cnt_d;
  logic       pay_seen_q, pay_seen_d;
  logic       started_q, started_d;
  logic [6:0] seq_q, seq_d;
  logic       seq_flag_q, seq_flag_d;
  logic [3:0] ck_hi_q, ck_hi_d;

  res_t [MaxRes-1:0] res;
  logic [1:0]        nres;

  always_comb begin
    logic       done;
    logic       clr;
    logic [4:0] hx;
    logic [7:0] dd;
    logic [7:0] cs;
    res_t       blank;

    phase_d     = phase_q;
    sum_d       = sum_q;
    esc_d       = esc_q;
    rep_d       = rep_q;
    last_data_d = last_data_q;
    held0_d     = held0_q;
    held1_d     = held1_q;
    held_cnt_d  = held_cnt_q;
    pay_seen_d  = pay_seen_q;
    started_d   = started_q;
    seq_d       = seq_q;
    seq_flag_d  = seq_flag_q;
    ck_hi_d     = ck_hi_q;
    blank       = '0;
    res         = '0;
    nres        = 2'd0;
    done        = 1'b0;
    clr         = 1'b0;
    hx          = hex_nibble(rx_byte_i);
    dd          = 8'd0;
    cs          = 8'd0;

    case (phase_q)
      PH_IDLE: begin
        if (eos_i) begin
          res[nres] = blank; res[nres].kind = KIND_EOF_IDLE; nres = nres + 2'd1;
        end else if (rx_byte_i == CH_PLUS) begin
          res[nres] = blank; res[nres].kind = KIND_ACK; nres = nres + 2'd1;
        end else if (rx_byte_i == CH_MINUS) begin
          res[nres] = blank; res[nres].kind = KIND_RETX; nres = nres + 2'd1;
        end else if (rx_byte_i == CH_INTR) begin
          res[nres] = blank; res[nres].kind = KIND_INTR; nres = nres + 2'd1;
        end else if (rx_byte_i == CH_DOLLAR) begin
          clr     = 1'b1;
          phase_d = PH_BODY;
        end else begin
          res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
        end
      end
      PH_BODY: begin
        if (eos_i) begin
          res[nres] = blank; res[nres].kind = KIND_TRUNCATED; nres = nres + 2'd1;
          clr = 1'b1; phase_d = PH_IDLE;
        end else if (!esc_q && !rep_q && rx_byte_i == CH_HASH) begin
          // flush held digits as payload
          if (held_cnt_q != 2'd0) begin
            res[nres] = blank; res[nres].data = held0_q; res[nres].repeat_res = 7'd1;
            nres = nres + 2'd1; last_data_d = held0_q; pay_seen_d = 1'b1;
          end
          if (held_cnt_q == 2'd2) begin
            res[nres] = blank; res[nres].data = held1_q; res[nres].repeat_res = 7'd1;
            nres = nres + 2'd1; last_data_d = held1_q;
          end
          held_cnt_d = 2'd0;
          phase_d    = PH_CK1;
        end else begin
          sum_d = sum_q + rx_byte_i;
          if (!started_q) begin
            if (held_cnt_q != 2'd2 && rx_byte_i inside {[8'h30:8'h39]}) begin
              if (held_cnt_q[0]) begin
                held1_d = rx_byte_i;
              end else begin
                held0_d = rx_byte_i;
              end
              held_cnt_d = held_cnt_q + 2'd1;
              done = 1'b1;
            end else if (held_cnt_q == 2'd2 && rx_byte_i == CH_COLON) begin
              seq_d      = 7'(7'(held0_q[3:0]) * 7'd10) + 7'(held1_q[3:0]);
              seq_flag_d = 1'b1;
              held_cnt_d = 2'd0;
              started_d  = 1'b1;
              done       = 1'b1;
            end else begin
              if (held_cnt_q != 2'd0) begin
                res[nres] = blank; res[nres].data = held0_q;
                res[nres].repeat_res = 7'd1;
                nres = nres + 2'd1; last_data_d = held0_q; pay_seen_d = 1'b1;
              end
              if (held_cnt_q == 2'd2) begin
                res[nres] = blank; res[nres].data = held1_q;
                res[nres].repeat_res = 7'd1;
                nres = nres + 2'd1; last_data_d = held1_q;
              end
              held_cnt_d = 2'd0;
              started_d  = 1'b1;
            end
          end
          if (!done) begin
            if (rx_byte_i == CH_HASH || rx_byte_i == CH_DOLLAR) begin
              res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
              clr = 1'b1; phase_d = PH_IDLE;
            end else if (rep_q) begin
              if (rx_byte_i < REP_BIAS || rx_byte_i > REP_TOP) begin
                res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
                clr = 1'b1; phase_d = PH_IDLE;
              end else begin
                dd = rx_byte_i - REP_BIAS;
                if (dd != 8'd0) begin
                  res[nres] = blank; res[nres].data = last_data_d;
                  res[nres].repeat_res = dd[6:0];
                  nres = nres + 2'd1; pay_seen_d = 1'b1;
                end
                rep_d = 1'b0;
              end
            end else if (rx_byte_i == CH_ESC) begin
              if (esc_q) begin
                res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
                clr = 1'b1; phase_d = PH_IDLE;
              end else begin
                esc_d = 1'b1;
              end
            end else if (rx_byte_i == CH_STAR && rle_enable_i) begin
              if (!pay_seen_d || esc_q) begin
                res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
                clr = 1'b1; phase_d = PH_IDLE;
              end else begin
                rep_d = 1'b1;
              end
            end else begin
              dd = esc_q ? (rx_byte_i ^ ESC_XOR) : rx_byte_i;
              last_data_d = dd;
              res[nres] = blank; res[nres].data = dd; res[nres].repeat_res = 7'd1;
              nres = nres + 2'd1; pay_seen_d = 1'b1;
              esc_d = 1'b0;
            end
          end
        end
      end
      PH_CK1: begin
        if (eos_i) begin
          res[nres] = blank; res[nres].kind = KIND_TRUNCATED; nres = nres + 2'd1;
          clr = 1'b1; phase_d = PH_IDLE;
        end else if (!hx[4]) begin
          res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
          clr = 1'b1; phase_d = PH_IDLE;
        end else begin
          ck_hi_d = hx[3:0];
          phase_d = PH_CK2;
        end
      end
      PH_CK2: begin
        if (eos_i) begin
          res[nres] = blank; res[nres].kind = KIND_TRUNCATED; nres = nres + 2'd1;
        end else if (!hx[4]) begin
          res[nres] = blank; res[nres].kind = KIND_INVALID; nres = nres + 2'd1;
        end else begin
          cs = {ck_hi_q, hx[3:0]};
          res[nres] = blank;
          res[nres].kind = (cs != sum_q) ? KIND_BAD_CSUM :
                           (pay_seen_q ? KIND_PKT_OK : KIND_EMPTY_OK);
          res[nres].seq_id    = seq_q;
          res[nres].seq_valid = seq_flag_q;
          res[nres].checksum  = cs;
          nres = nres + 2'd1;
        end
        clr = 1'b1; phase_d = PH_IDLE;
      end
      default: begin
        clr = 1'b1; phase_d = PH_IDLE;
      end
    endcase

    if (clr) begin
      sum_d       = 8'd0;
      esc_d       = 1'b0;
      rep_d       = 1'b0;
      last_data_d = 8'd0;
      held0_d     = 8'd0;
      held1_d     = 8'd0;
      held_cnt_d  = 2'd0;
      pay_seen_d  = 1'b0;
      started_d   = 1'b0;
      seq_d       = 7'd0;
      seq_flag_d  = 1'b0;
      ck_hi_d     = 4'd0;
    end
  end

  assign push_o       = accept_i && (nres != 2'd0);
  assign bundle_o.cnt = nres;
  assign bundle_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      sum_q       <= 8'd0;
      esc_q       <= 1'b0;
      rep_q       <= 1'b0;
      last_data_q <= 8'd0;
      held0_q     <= 8'd0;
      held1_q     <= 8'd0;
      held_cnt_q  <= 2'd0;
      pay_seen_q  <= 1'b0;
      started_q   <= 1'b0;
      seq_q       <= 7'd0;
      seq_flag_q  <= 1'b0;
      ck_hi_q     <= 4'd0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      esc_q       <= esc_d;
      rep_q       <= rep_d;
      last_data_q <= last_data_d;
      held0_q     <= held0_d;
      held1_q     <= held1_d;
      held_cnt_q  <= held_cnt_d;
      pay_seen_q  <= pay_seen_d;
      started_q   <= started_d;
      seq_q       <= seq_d;
      seq_flag_q  <= seq_flag_d;
      ck_hi_q     <= ck_hi_d;
    end
  end

endmodule

// ===== sv/rpd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_queue
// Small register queue of result bundles between front and back.
// ----------------------------------------------------------------------------
module rpd_queue import rpd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  bundle_t bundle_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output q_stat_t stat_o
);

  bundle_t           mem_q [QDepth];
  logic [QPtrW-1:0]  wptr_q;
  logic [QPtrW-1:0]  rptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== sv/rpd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpd_back
// Walks the results of the head bundle and presents them one per transfer.
// ----------------------------------------------------------------------------
module rpd_back import rpd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bundle_t    head_i,
  input  q_stat_t    stat_i,
  output logic       pop_o,
  rpd_out_if.source  res_o
);

  logic [1:0] idx_q, idx_d;
  res_t       cur;
  logic       is_last;
  logic       xfer;

  always_comb begin
    case (idx_q)
      2'd1:    cur = head_i.res[1];
      2'd2:    cur = head_i.res[2];
      default: cur = head_i.res[0];
    endcase
  end

  assign is_last = (idx_q == 2'(head_i.cnt - 2'd1));
  assign xfer    = res_o.valid && res_o.ready;
  assign pop_o   = xfer && is_last;
  assign idx_d   = pop_o ? 2'd0 : (xfer ? idx_q + 2'd1 : idx_q);

  assign res_o.valid      = !stat_i.empty;
  assign res_o.kind       = cur.kind;
  assign res_o.data       = cur.data;
  assign res_o.repeat_res = cur.repeat_res;
  assign res_o.seq_id     = cur.seq_id;
  assign res_o.seq_valid  = cur.seq_valid;
  assign res_o.checksum   = cur.checksum;
  assign res_o.last       = is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

endmodule

// ===== sv/rsp_packet_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer_unit
// Byte-serial deframer for remote-debug packets with streamed payload output.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                        | transfer
//  rx_i     | in  | rx_byte, end_of_stream                         | valid & ready
//  res_o    | out | kind, data, repeat_res, seq_id, seq_valid,     | valid & ready
//           |     | checksum, last                                 |
//  cfg_i    | in  | rle_enable                                     | valid & ready
//
//  one byte is taken per cycle while the four-entry bundle queue has room
//  each byte yields zero to three results, sent one per cycle unless res_o stalls
//  a result is registered in the bundle queue and sent from the queue head
//  reset clears the framing state and the queue; rle_enable resets to 1
//  cfg_i is always ready; output stalls back up through the queue to rx_i
// ----------------------------------------------------------------------------
module rsp_packet_deframer_unit import rpd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rpd_in_if.sink    rx_i,
  rpd_out_if.source res_o,
  rpd_cfg_if.sink   cfg_i
);

  logic    rle_q;
  logic    accept;
  logic    push;
  logic    pop;
  bundle_t bundle;
  bundle_t head;
  q_stat_t stat;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q <= 1'b1;
    end else if (cfg_i.valid) begin
      rle_q <= cfg_i.rle_enable;
    end
  end

  assign rx_i.ready = !stat.full;
  assign accept     = rx_i.valid && rx_i.ready;

  rpd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rle_enable_i (rle_q),
    .accept_i     (accept),
    .rx_byte_i    (rx_i.rx_byte),
    .eos_i        (rx_i.end_of_stream),
    .push_o       (push),
    .bundle_o     (bundle)
  );

  rpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .pop_i    (pop),
    .head_o   (head),
    .stat_o   (stat)
  );

  rpd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .stat_i (stat),
    .pop_o  (pop),
    .res_o  (res_o)
  );

`ifndef SYNTHESIS
  a_push_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> bundle.cnt != 2'd0)
    else $error("empty bundle pushed");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("push into full queue");

  a_head_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> head.cnt != 2'd0)
    else $error("queue head holds no results");

  a_payload_rep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.kind == KIND_PAYLOAD) |-> res_o.repeat_res != 7'd0)
    else $error("payload result with zero repeat");
`endif

endmodule

// ===== test/rsp_packet_deframer_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsp_packet_deframer_unit_test
// Self-checking bench for the packet deframer. A queue-fed driver offers
// control bytes, framed packets and broken sequences. A shadow deframer
// predicts every result of each accepted byte, and a monitor compares the
// result transfers in order. The run covers both rle settings and several
// idle, stall and back-pressure mixes.
// ----------------------------------------------------------------------------
module rsp_packet_deframer_unit_test;
  import rpd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxShown   = 10;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;

  typedef enum logic [1:0] {FR_IDLE, FR_BODY, FR_CK_HI, FR_CK_LO} frame_phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       eos;
  } rx_item_t;

  typedef struct packed {
    res_t res;
    logic last;
  } res_entry_t;

  logic clk_i;
  logic rst_ni;

  rpd_in_if  rx_if ();
  rpd_out_if res_if ();
  rpd_cfg_if cfg_if ();

  rsp_packet_deframer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  rx_item_t    rx_backlog[$];
  res_entry_t  pending_results[$];
  res_t        step_res[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned items_queued   = 0;
  logic [7:0]  frame_sum      = '0;

  // shadow deframer state
  frame_phase_e fr_phase    = FR_IDLE;
  logic         rle_on      = 1'b1;
  logic [7:0]   body_sum    = '0;
  logic         esc_wait    = 1'b0;
  logic         rep_wait    = 1'b0;
  logic [7:0]   prev_data   = '0;
  logic [7:0]   digit_hold[2];
  int unsigned  digit_cnt   = 0;
  logic         saw_payload = 1'b0;
  logic         prefix_done = 1'b0;
  logic [6:0]   seq_num     = '0;
  logic         seq_seen    = 1'b0;
  logic [3:0]   ck_high     = '0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void add_result(kind_e k, logic [7:0] d, logic [6:0] rep,
                                     logic [6:0] sq, logic sv, logic [7:0] cs);
    res_t r;
    r.kind       = k;
    r.data       = d;
    r.repeat_res = rep;
    r.seq_id     = sq;
    r.seq_valid  = sv;
    r.checksum   = cs;
    step_res.push_back(r);
  endfunction

  function automatic void add_payload(logic [7:0] d, logic [6:0] rep);
    saw_payload = 1'b1;
    add_result(KIND_PAYLOAD, d, rep, '0, 1'b0, '0);
  endfunction

  function automatic void clear_frame();
    body_sum      = '0;
    esc_wait      = 1'b0;
    rep_wait      = 1'b0;
    prev_data     = '0;
    digit_hold[0] = '0;
    digit_hold[1] = '0;
    digit_cnt     = 0;
    saw_payload   = 1'b0;
    prefix_done   = 1'b0;
    seq_num       = '0;
    seq_seen      = 1'b0;
    ck_high       = '0;
  endfunction

  function automatic void abort_frame(kind_e k);
    add_result(k, '0, '0, '0, 1'b0, '0);
    clear_frame();
    fr_phase = FR_IDLE;
  endfunction

  // digits held back as a possible sequence id turn out to be payload
  function automatic void release_digits();
    for (int i = 0; i < digit_cnt; i++) begin
      prev_data = digit_hold[i];
      add_payload(digit_hold[i], 7'd1);
    end
    digit_cnt = 0;
  endfunction

  function automatic logic hex_ok(input logic [7:0] b, output logic [3:0] nib);
    logic ok;
    ok  = 1'b1;
    nib = '0;
    if (b >= CH_ZERO && b <= CH_NINE) begin
      nib = 4'(b - CH_ZERO);
    end else if (b >= CH_LA && b <= CH_LF) begin
      nib = 4'(b - CH_LA + 8'd10);
    end else if (b >= CH_UA && b <= CH_UF) begin
      nib = 4'(b - CH_UA + 8'd10);
    end else begin
      ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void body_byte(logic [7:0] b);
    logic [7:0] d;
    if (!esc_wait && !rep_wait && b == CH_HASH) begin
      release_digits();
      fr_phase = FR_CK_HI;
      return;
    end
    body_sum = body_sum + b;
    if (!prefix_done) begin
      if (digit_cnt < 2 && b >= CH_ZERO && b <= CH_NINE) begin
        digit_hold[digit_cnt] = b;
        digit_cnt++;
        return;
      end
      if (digit_cnt == 2 && b == CH_COLON) begin
        seq_num     = 7'((digit_hold[0] - CH_ZERO) * 10 + (digit_hold[1] - CH_ZERO));
        seq_seen    = 1'b1;
        digit_cnt   = 0;
        prefix_done = 1'b1;
        return;
      end
      release_digits();
      prefix_done = 1'b1;
    end
    if (b == CH_HASH || b == CH_DOLLAR) begin
      abort_frame(KIND_INVALID);
      return;
    end
    if (rep_wait) begin
      if (b < REP_BIAS || b > REP_TOP) begin
        abort_frame(KIND_INVALID);
        return;
      end
      if (b != REP_BIAS) add_payload(prev_data, 7'(b - REP_BIAS));
      rep_wait = 1'b0;
    end else if (b == CH_ESC) begin
      if (esc_wait) begin
        abort_frame(KIND_INVALID);
        return;
      end
      esc_wait = 1'b1;
    end else if (b == CH_STAR && rle_on) begin
      if (!saw_payload || esc_wait) begin
        abort_frame(KIND_INVALID);
        return;
      end
      rep_wait = 1'b1;
    end else begin
      d = esc_wait ? (b ^ ESC_XOR) : b;
      prev_data = d;
      add_payload(d, 7'd1);
      esc_wait = 1'b0;
    end
  endfunction

  // works out every result of one accepted byte
  function automatic void deframe_byte(logic [7:0] b, logic eos);
    logic [3:0] nib;
    logic [7:0] cs;
    res_entry_t e;
    step_res.delete();
    case (fr_phase)
      FR_IDLE: begin
        if (eos) add_result(KIND_EOF_IDLE, '0, '0, '0, 1'b0, '0);
        else if (b == CH_PLUS) add_result(KIND_ACK, '0, '0, '0, 1'b0, '0);
        else if (b == CH_MINUS) add_result(KIND_RETX, '0, '0, '0, 1'b0, '0);
        else if (b == CH_INTR) add_result(KIND_INTR, '0, '0, '0, 1'b0, '0);
        else if (b == CH_DOLLAR) begin
          clear_frame();
          fr_phase = FR_BODY;
        end else add_result(KIND_INVALID, '0, '0, '0, 1'b0, '0);
      end
      FR_BODY: begin
        if (eos) abort_frame(KIND_TRUNCATED);
        else body_byte(b);
      end
      FR_CK_HI: begin
        if (eos) abort_frame(KIND_TRUNCATED);
        else if (!hex_ok(b, nib)) abort_frame(KIND_INVALID);
        else begin
          ck_high  = nib;
          fr_phase = FR_CK_LO;
        end
      end
      FR_CK_LO: begin
        if (eos) abort_frame(KIND_TRUNCATED);
        else if (!hex_ok(b, nib)) abort_frame(KIND_INVALID);
        else begin
          cs = {ck_high, nib};
          if (cs != body_sum) add_result(KIND_BAD_CSUM, '0, '0, seq_num, seq_seen, cs);
          else add_result(saw_payload ? KIND_PKT_OK : KIND_EMPTY_OK, '0, '0, seq_num,
                          seq_seen, cs);
          clear_frame();
          fr_phase = FR_IDLE;
        end
      end
      default: begin
        clear_frame();
        fr_phase = FR_IDLE;
      end
    endcase
    foreach (step_res[i]) begin
      e.res  = step_res[i];
      e.last = (i == step_res.size() - 1);
      pending_results.push_back(e);
    end
  endfunction

  function automatic void queue_byte(logic [7:0] b);
    rx_item_t it;
    it.rx_byte = b;
    it.eos     = 1'b0;
    rx_backlog.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_eos();
    rx_item_t it;
    it.rx_byte = 8'($urandom);
    it.eos     = 1'b1;
    rx_backlog.push_back(it);
    items_queued++;
  endfunction

  function automatic void queue_body(logic [7:0] b);
    frame_sum = frame_sum + b;
    queue_byte(b);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib, logic upper);
    if (nib < 4'd10) return CH_ZERO + nib;
    return (upper ? CH_UA : CH_LA) + nib - 8'd10;
  endfunction

  function automatic void queue_checksum(logic [7:0] cs);
    logic upper;
    upper = 1'($urandom_range(1));
    queue_byte(hex_char(cs[7:4], upper));
    queue_byte(hex_char(cs[3:0], upper));
  endfunction

  function automatic void queue_text_frame(string body, logic good);
    frame_sum = '0;
    queue_byte(CH_DOLLAR);
    for (int i = 0; i < body.len(); i++) queue_body(body[i]);
    queue_byte(CH_HASH);
    queue_checksum(good ? frame_sum : (frame_sum ^ 8'h5a));
  endfunction

  // mostly well-formed packet with random content, sometimes broken
  function automatic void queue_random_frame();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  d;
    logic        any_data;
    frame_sum = '0;
    any_data  = 1'b0;
    queue_byte(CH_DOLLAR);
    if ($urandom_range(2) == 0) begin
      queue_body(CH_ZERO + 8'($urandom_range(9)));
      queue_body(CH_ZERO + 8'($urandom_range(9)));
      queue_body(CH_COLON);
    end
    n = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(5);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        case ($urandom_range(3))
          0: queue_body(CH_DOLLAR);
          1: begin
            queue_body(CH_ESC);
            queue_body(CH_ESC);
          end
          2: queue_body(CH_STAR);
          default: begin
            queue_body(CH_ESC);
            queue_body(CH_HASH);
          end
        endcase
      end else if (pick < 20 && any_data && rle_on) begin
        queue_body(CH_STAR);
        case ($urandom_range(7))
          0: queue_body(REP_BIAS);
          1: queue_body(REP_TOP);
          2: queue_body(REP_BIAS - 8'd1);
          3: queue_body(REP_TOP + 8'd1);
          default: queue_body(8'($urandom_range(REP_TOP, REP_BIAS)));
        endcase
      end else begin
        if ($urandom_range(5) == 0) begin
          case ($urandom_range(3))
            0: d = CH_HASH;
            1: d = CH_DOLLAR;
            2: d = CH_ESC;
            default: d = CH_STAR;
          endcase
        end else begin
          d = 8'($urandom);
        end
        if (d == CH_HASH || d == CH_DOLLAR || d == CH_ESC || (d == CH_STAR && rle_on) ||
            $urandom_range(9) == 0) begin
          queue_body(CH_ESC);
          queue_body(d ^ ESC_XOR);
        end else begin
          queue_body(d);
        end
        any_data = 1'b1;
      end
    end
    case ($urandom_range(15))
      0: queue_eos();
      1: begin
        queue_byte(CH_HASH);
        queue_eos();
      end
      2: begin
        queue_byte(CH_HASH);
        queue_byte(8'($urandom));
        queue_byte(hex_char(4'($urandom), 1'b0));
      end
      3: begin
        queue_byte(CH_HASH);
        queue_checksum(frame_sum + 8'($urandom_range(255, 1)));
      end
      4: begin
        queue_byte(CH_HASH);
        queue_byte(hex_char(frame_sum[7:4], 1'b1));
        queue_eos();
      end
      5: begin
        queue_byte(CH_HASH);
        queue_byte(hex_char(frame_sum[7:4], 1'b0));
        queue_byte(8'($urandom));
      end
      default: begin
        queue_byte(CH_HASH);
        queue_checksum(frame_sum);
      end
    endcase
  endfunction

  task automatic drain();
    do @(negedge clk_i); while (rx_backlog.size() != 0 || pending_results.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(logic write_cfg, logic rle_v, int unsigned idle_pct,
                           int unsigned stall_pct, int unsigned hold_cycles,
                           int unsigned n_items);
    int unsigned start;
    if (write_cfg) begin
      @(posedge clk_i);
      cfg_if.valid      <= 1'b1;
      cfg_if.rle_enable <= rle_v;
      @(posedge clk_i);
      while (!cfg_if.ready) @(posedge clk_i);
      rle_on = rle_v;
      cfg_if.valid <= 1'b0;
    end
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    start = items_queued;
    while (items_queued - start < n_items) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(5))
          0: queue_byte(CH_PLUS);
          1: queue_byte(CH_MINUS);
          2: queue_byte(CH_INTR);
          3: queue_eos();
          default: queue_byte(8'($urandom));
        endcase
      end else begin
        queue_random_frame();
      end
    end
    if (hold_cycles != 0) begin
      @(posedge clk_i);
      hold_left <= hold_cycles;
    end
    drain();
  endtask

  // byte driver
  always @(posedge clk_i) begin : byte_feed
    logic busy;
    if (!rst_ni) begin
      rx_if.valid <= 1'b0;
    end else begin
      busy = rx_if.valid;
      if (rx_if.valid && rx_if.ready) begin
        deframe_byte(rx_if.rx_byte, rx_if.end_of_stream);
        void'(rx_backlog.pop_front());
        busy = 1'b0;
      end
      if (!busy) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_if.valid         <= 1'b1;
          rx_if.rx_byte       <= rx_backlog[0].rx_byte;
          rx_if.end_of_stream <= rx_backlog[0].eos;
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_check
    res_entry_t seen;
    res_entry_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        seen.res.kind       = kind_e'(res_if.kind);
        seen.res.data       = res_if.data;
        seen.res.repeat_res = res_if.repeat_res;
        seen.res.seq_id     = res_if.seq_id;
        seen.res.seq_valid  = res_if.seq_valid;
        seen.res.checksum   = res_if.checksum;
        seen.last           = res_if.last;
        if (pending_results.size() == 0) begin
          if (mismatches < MaxShown)
            $display("unexpected result: kind %0d data %h", res_if.kind, res_if.data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (seen !== want) begin
            if (mismatches < MaxShown)
              $display({"result mismatch (exp/got): kind %0d/%0d data %h/%h rep %0d/%0d ",
                        "seq %0d/%0d sv %0b/%0b csum %h/%h last %0b/%0b"},
                       want.res.kind, seen.res.kind, want.res.data, seen.res.data,
                       want.res.repeat_res, seen.res.repeat_res, want.res.seq_id,
                       seen.res.seq_id, want.res.seq_valid, seen.res.seq_valid,
                       want.res.checksum, seen.res.checksum, want.last, seen.last);
            mismatches++;
          end
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("rsp_packet_deframer_unit_test NOT OK");
      $finish;
    end
  end

  initial begin
    rst_ni              = 1'b0;
    rx_if.valid         = 1'b0;
    rx_if.rx_byte       = '0;
    rx_if.end_of_stream = 1'b0;
    res_if.ready        = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.rle_enable   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // control bytes, stray byte, end of stream while idle
    queue_byte(CH_PLUS);
    queue_byte(CH_MINUS);
    queue_byte(CH_INTR);
    queue_byte(8'hff);
    queue_eos();
    // empty packet, sequence id with escape and run, bad checksum
    queue_text_frame("", 1'b1);
    queue_text_frame("42:}]x* ", 1'b1);
    queue_text_frame("7a", 1'b0);
    // run marker at payload start, then a cut-off packet
    queue_byte(CH_DOLLAR);
    queue_byte(CH_STAR);
    queue_byte(CH_DOLLAR);
    queue_eos();
    drain();

    run_phase(1'b0, 1'b1, 0, 0, 0, 40);
    run_phase(1'b1, 1'b0, 71, 0, 0, 40);
    run_phase(1'b1, 1'b1, 0, 71, 0, 40);
    run_phase(1'b1, 1'b0, 31, 31, 0, 40);
    run_phase(1'b1, 1'b1, 0, 0, 300, 40);

    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("rsp_packet_deframer_unit_test OK");
    end else begin
      $display("rsp_packet_deframer_unit_test NOT OK");
    end
    $finish;
  end

endmodule
